// ===== src/rzpr_pkg.sv =====
// Shared types and constants for the rotate/zoom pixel resampler.
// No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps

package rzpr_pkg;

    localparam int DEF_FRAME_WIDTH  = 512;
    localparam int DEF_FRAME_HEIGHT = 512;

    localparam int COORD_W = 9;
    localparam int CHAN_W  = 8;
    localparam int PIXEL_W = 3 * CHAN_W;
    localparam int COEF_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W  = 2;

    // Offsets from the frame center, in half-pixel units.
    localparam int DELTA_W = 12;
    localparam int PROD_W  = DELTA_W + COEF_W;
    localparam int ACC_W   = PROD_W + 2;
    // Mapped positions are in units of 2^-17 pixel.
    localparam int FRAC_W  = 17;
    localparam int MAG_W   = ACC_W - FRAC_W;

    // Channel sums of a three by three box, and the reciprocal of nine.
    localparam int SUM_W      = 12;
    localparam int RECIP_W    = 13;
    localparam int RECIP_SH   = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

    localparam logic [CFG_IDX_W-1:0] CFG_COS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_BLANK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOX     = 2'd2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [COEF_W-1:0] COS_RESET = 32'h0001_0000;
    localparam logic [COEF_W-1:0] SIN_RESET = 32'h0000_0000;

    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] pixel_row;
        logic [COORD_W-1:0] pixel_col;
        logic [CHAN_W-1:0]  red_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  blue_in;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              outside_frame;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_ROUND,
        ST_CHECK,
        ST_READ,
        ST_SETTLE,
        ST_FINISH
    } state_t;

endpackage

// ===== src/rzpr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; used for the frame store.
`timescale 1ns / 1ps

module rzpr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/rotate_zoom_pixel_resampler_unit.sv =====
// Rotate/zoom resampler top level: frame store, inverse mapping and sampling sequencer.
// Depends on rzpr_pkg and rzpr_ram.
`timescale 1ns / 1ps

//  channel  | signals                             | moves
//  ---------+-------------------------------------+---------------------------------------
//  input    | in_valid, in_ready, in_data         | pixel write or render request
//  output   | out_valid, out_ready, out_data      | rendered pixel, one per render request
//  config   | cfg_write_en, cfg_index, cfg_data   | coefficient and mode writes
//
// A pixel write is done at its transfer. A render steps through the sequencer states in
// order: the four products through one shared 12x32 multiplier, rounding, the range
// check, one frame store read per sample through the single read port, a settle state
// for the last read to land and a final state that registers the result. A blank render
// goes from its transfer straight to the final state, and an off-frame render goes there
// from the range check. The next transfer can be taken in the cycle after the result is
// registered. A finished result sits in the output register, so the next transfer is
// taken while it waits; the sequencer stalls in its last state only while the output
// register still holds an untaken result. Reset clears control state and sets the
// configuration registers to their reset values; the frame store is not cleared.

module rotate_zoom_pixel_resampler_unit #(
    parameter int FRAME_WIDTH  = rzpr_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = rzpr_pkg::DEF_FRAME_HEIGHT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  rzpr_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output rzpr_pkg::out_item_t                   out_data,
    input  logic                                  cfg_write_en,
    input  logic [rzpr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rzpr_pkg::COEF_W-1:0]           cfg_data
);

    import rzpr_pkg::*;

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(FRAME_HEIGHT);
    localparam int COL_W  = $clog2(FRAME_WIDTH);
    localparam logic signed [ACC_W-1:0] CENTER_R = ACC_W'(FRAME_HEIGHT) <<< 16;
    localparam logic signed [ACC_W-1:0] CENTER_C = ACC_W'(FRAME_WIDTH) <<< 16;
    localparam logic signed [ACC_W-1:0] HALF_PIX = ACC_W'(65536);
    localparam logic [2:0] MUL_LAST = 3'd4;
    localparam logic [3:0] TAP_BOX_LAST = 4'd8;

    state_t state_reg, state_next;

    logic signed [COEF_W-1:0] cos_reg, sin_reg;
    logic [MODE_W-1:0]        mode_reg;

    logic [COORD_W-1:0]       row_reg, col_reg;
    logic [2:0]               mul_step_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_r_reg, acc_c_reg;
    logic [MAG_W-1:0]         mag_r_reg, mag_c_reg;
    logic                     neg_r_reg, neg_c_reg;
    logic                     blank_reg;
    logic                     box_reg;
    logic [ADDR_W-1:0]        base_reg;
    logic [3:0]               tap_reg;
    logic                     rd_pending_reg;
    logic [SUM_W-1:0]         sum_r_reg, sum_g_reg, sum_b_reg;
    logic                     out_valid_reg;
    out_item_t                out_reg;

    // Combinational signals.
    logic                     accept;
    logic                     wr_in_frame;
    logic                     mem_wr_en, mem_rd_en;
    logic [ADDR_W-1:0]        wr_addr, rd_addr, row_addr;
    logic [PIXEL_W-1:0]       rd_data;
    logic signed [DELTA_W-1:0] dr2, dc2, mul_a;
    logic signed [COEF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  mag_r_full, mag_c_full;
    logic                     row_ok, col_ok, in_frame, box_inner;
    logic [ROW_W-1:0]         src_row;
    logic [COL_W-1:0]         src_col;
    logic [3:0]               tap_last;
    logic                     out_free;
    logic [SUM_W+RECIP_W-1:0] div_r, div_g, div_b;

    // ------------------------------------------------------------------
    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg  <= COS_RESET;
            sin_reg  <= SIN_RESET;
            mode_reg <= MODE_NEAREST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_COS:  cos_reg  <= cfg_data;
                CFG_SIN:  sin_reg  <= cfg_data;
                CFG_MODE: mode_reg <= cfg_data[MODE_W-1:0];
                default:  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame store.
    rzpr_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_addr),
        .wr_data ({in_data.red_in, in_data.green_in, in_data.blue_in}),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign wr_in_frame = ({2'b00, in_data.pixel_row} < 11'(FRAME_HEIGHT))
                      && ({2'b00, in_data.pixel_col} < 11'(FRAME_WIDTH));
    assign wr_addr = ADDR_W'(in_data.pixel_row) * ADDR_W'(FRAME_WIDTH)
                   + ADDR_W'(in_data.pixel_col);

    // ------------------------------------------------------------------
    // Shared multiplier: the four rotation products, one per cycle.
    assign dr2 = $signed({2'b00, row_reg, 1'b0}) - DELTA_W'(FRAME_HEIGHT);
    assign dc2 = $signed({2'b00, col_reg, 1'b0}) - DELTA_W'(FRAME_WIDTH);

    always_comb
    begin
        unique case (mul_step_reg[1:0])
            2'd0:
            begin
                mul_a = dr2;
                mul_b = cos_reg;
            end
            2'd1:
            begin
                mul_a = dc2;
                mul_b = sin_reg;
            end
            2'd2:
            begin
                mul_a = dr2;
                mul_b = sin_reg;
            end
            default:
            begin
                mul_a = dc2;
                mul_b = cos_reg;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Rounding half away from zero works on the magnitude.
    assign mag_r_full = acc_r_reg[ACC_W-1] ? (HALF_PIX - acc_r_reg) : (acc_r_reg + HALF_PIX);
    assign mag_c_full = acc_c_reg[ACC_W-1] ? (HALF_PIX - acc_c_reg) : (acc_c_reg + HALF_PIX);

    // A negative position that rounds to zero is still row or column zero.
    assign row_ok = (!neg_r_reg || (mag_r_reg == '0)) && (mag_r_reg < MAG_W'(FRAME_HEIGHT));
    assign col_ok = (!neg_c_reg || (mag_c_reg == '0)) && (mag_c_reg < MAG_W'(FRAME_WIDTH));
    assign in_frame = row_ok && col_ok;
    assign src_row = mag_r_reg[ROW_W-1:0];
    assign src_col = mag_c_reg[COL_W-1:0];
    assign box_inner = (mag_r_reg >= MAG_W'(1)) && (mag_r_reg <= MAG_W'(FRAME_HEIGHT - 2))
                    && (mag_c_reg >= MAG_W'(1)) && (mag_c_reg <= MAG_W'(FRAME_WIDTH - 2));

    assign tap_last = box_reg ? TAP_BOX_LAST : 4'd0;

    // Box taps walk the rows above, at and below the center, left to right.
    always_comb
    begin
        row_addr = base_reg;
        rd_addr  = base_reg;
        if (box_reg)
        begin
            unique case (tap_reg)
                4'd0, 4'd1, 4'd2: row_addr = base_reg - ADDR_W'(FRAME_WIDTH);
                4'd6, 4'd7, 4'd8: row_addr = base_reg + ADDR_W'(FRAME_WIDTH);
                default:          row_addr = base_reg;
            endcase
            unique case (tap_reg)
                4'd0, 4'd3, 4'd6: rd_addr = row_addr - ADDR_W'(1);
                4'd2, 4'd5, 4'd8: rd_addr = row_addr + ADDR_W'(1);
                default:          rd_addr = row_addr;
            endcase
        end
    end

    assign div_r = sum_r_reg * RECIP_NINE;
    assign div_g = sum_g_reg * RECIP_NINE;
    assign div_b = sum_b_reg * RECIP_NINE;

    assign out_free = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_data.opcode == OP_RENDER))
                begin
                    state_next = (mode_reg == MODE_BLANK) ? ST_FINISH : ST_MAP;
                end
            end
            ST_MAP:
            begin
                if (mul_step_reg == MUL_LAST)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = in_frame ? ST_READ : ST_FINISH;
            end
            ST_READ:
            begin
                if (tap_reg == tap_last)
                begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        accept    = in_ready && in_valid;
        mem_wr_en = accept && (in_data.opcode == OP_WRITE) && wr_in_frame;
        mem_rd_en = (state_reg == ST_READ);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mul_step_reg   <= '0;
            tap_reg        <= '0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pending_reg <= mem_rd_en;

            if (state_reg == ST_MAP)
            begin
                mul_step_reg <= (mul_step_reg == MUL_LAST) ? 3'd0 : mul_step_reg + 3'd1;
            end

            if (state_reg == ST_READ)
            begin
                tap_reg <= (tap_reg == tap_last) ? 4'd0 : tap_reg + 4'd1;
            end

            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg   <= in_data.pixel_row;
            col_reg   <= in_data.pixel_col;
            blank_reg <= (mode_reg == MODE_BLANK);
        end

        if (state_reg == ST_MAP)
        begin
            prod_reg <= prod_next;
            unique case (mul_step_reg)
                3'd1:    acc_r_reg <= ACC_W'(prod_reg) + CENTER_R;
                3'd2:    acc_r_reg <= acc_r_reg - ACC_W'(prod_reg);
                3'd3:    acc_c_reg <= ACC_W'(prod_reg) + CENTER_C;
                3'd4:    acc_c_reg <= acc_c_reg + ACC_W'(prod_reg);
                default: ;
            endcase
        end

        if (state_reg == ST_ROUND)
        begin
            neg_r_reg <= acc_r_reg[ACC_W-1];
            neg_c_reg <= acc_c_reg[ACC_W-1];
            mag_r_reg <= mag_r_full[ACC_W-1:FRAC_W];
            mag_c_reg <= mag_c_full[ACC_W-1:FRAC_W];
        end

        if (state_reg == ST_CHECK)
        begin
            blank_reg <= !in_frame;
            box_reg   <= (mode_reg == MODE_BOX) && box_inner;
            base_reg  <= ADDR_W'(src_row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(src_col);
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
        end
        else if (rd_pending_reg)
        begin
            sum_r_reg <= sum_r_reg + SUM_W'(rd_data[3*CHAN_W-1:2*CHAN_W]);
            sum_g_reg <= sum_g_reg + SUM_W'(rd_data[2*CHAN_W-1:CHAN_W]);
            sum_b_reg <= sum_b_reg + SUM_W'(rd_data[CHAN_W-1:0]);
        end

        if ((state_reg == ST_FINISH) && out_free)
        begin
            if (blank_reg)
            begin
                out_reg.red_out       <= '0;
                out_reg.green_out     <= '0;
                out_reg.blue_out      <= '0;
                out_reg.outside_frame <= 1'b1;
            end
            else if (box_reg)
            begin
                out_reg.red_out       <= div_r[RECIP_SH+CHAN_W-1:RECIP_SH];
                out_reg.green_out     <= div_g[RECIP_SH+CHAN_W-1:RECIP_SH];
                out_reg.blue_out      <= div_b[RECIP_SH+CHAN_W-1:RECIP_SH];
                out_reg.outside_frame <= 1'b0;
            end
            else
            begin
                out_reg.red_out       <= sum_r_reg[CHAN_W-1:0];
                out_reg.green_out     <= sum_g_reg[CHAN_W-1:0];
                out_reg.blue_out      <= sum_b_reg[CHAN_W-1:0];
                out_reg.outside_frame <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== tb/sv/rotate_zoom_pixel_resampler_unit_tb.sv =====
// Self-checking testbench for the rotate/zoom pixel resampler: random pixel writes and
// renders through valid/ready channels, checked against an inverse-mapping predictor.
// Depends on rzpr_pkg and rotate_zoom_pixel_resampler_unit.
`timescale 1ns / 1ps

module rotate_zoom_pixel_resampler_unit_tb;

    import rzpr_pkg::*;

    localparam int FRAME_W     = DEF_FRAME_WIDTH;
    localparam int FRAME_H     = DEF_FRAME_HEIGHT;
    localparam int FRAME_CELLS = FRAME_W * FRAME_H;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_ALT_NEAREST = 2'd3;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data = '0;

    // Shadow of the block's registers, updated from the write port itself.
    logic signed [COEF_W-1:0] coef_cos;
    logic signed [COEF_W-1:0] coef_sin;
    logic [MODE_W-1:0]        mode_reg;

    logic [PIXEL_W-1:0] frame_mem [FRAME_CELLS];
    bit                 planned [FRAME_CELLS];
    int                 written_cells[$];

    in_item_t  pending_items[$];
    out_item_t expected_pixels[$];

    int          items_queued = 0;
    int          items_taken = 0;
    int          results_seen = 0;
    int          fail_count = 0;
    int          stall_cycles = 0;
    int          in_wait = 0;
    int          out_wait = 0;
    int unsigned in_gap_max = 13;
    int unsigned out_gap_max = 13;

    rotate_zoom_pixel_resampler_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Value in units of 2^-17 pixel to the nearest integer, halves away from zero.
    function automatic longint round_q17(input longint v);
        if (v >= 0)
            return (v + 65536) >>> 17;
        return -((65536 - v) >>> 17);
    endfunction

    // Frame store cells that a render at (row, col) reads under the current settings.
    // An empty list means a black pixel flagged outside the frame.
    function automatic void find_taps(input logic [COORD_W-1:0] row, col, output int taps[$]);
        longint src_r;
        longint src_c;
        taps = {};
        if (mode_reg == MODE_BLANK)
            return;
        src_r = round_q17((2 * longint'(row) - FRAME_H) * longint'(coef_cos)
                          - (2 * longint'(col) - FRAME_W) * longint'(coef_sin)
                          + (longint'(FRAME_H) <<< 16));
        src_c = round_q17((2 * longint'(row) - FRAME_H) * longint'(coef_sin)
                          + (2 * longint'(col) - FRAME_W) * longint'(coef_cos)
                          + (longint'(FRAME_W) <<< 16));
        if (src_r < 0 || src_r >= FRAME_H || src_c < 0 || src_c >= FRAME_W)
            return;
        // The box only applies away from the outer ring; the ring takes the nearest pixel.
        if (mode_reg == MODE_BOX && src_r >= 1 && src_r < FRAME_H - 1
            && src_c >= 1 && src_c < FRAME_W - 1)
        begin
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                    taps.push_back(int'((src_r + dr) * FRAME_W + src_c + dc));
            end
        end
        else
            taps.push_back(int'(src_r * FRAME_W + src_c));
    endfunction

    function automatic int unsigned draw_gap_limit();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 3;
            default: return 13;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] draw_coef();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3, 4: return 32'($urandom_range(0, 65536)) - 32'd32768;
            default: return 32'($urandom_range(0, 262144)) - 32'd131072;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_cos <= COS_RESET;
            coef_sin <= SIN_RESET;
            mode_reg <= MODE_NEAREST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_COS:  coef_cos <= cfg_data;
                CFG_SIN:  coef_sin <= cfg_data;
                CFG_MODE: mode_reg <= cfg_data[MODE_W-1:0];
                default:  ;
            endcase
        end
    end

    // Input side: feeds pending items, models writes and predicts renders at transfer.
    always @(posedge clk or negedge rst_n)
    begin : input_driver
        int        taps[$];
        int        sum_r;
        int        sum_g;
        int        sum_b;
        out_item_t want;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (in_data.opcode == OP_WRITE)
                begin
                    if (int'(in_data.pixel_row) < FRAME_H && int'(in_data.pixel_col) < FRAME_W)
                        frame_mem[int'(in_data.pixel_row) * FRAME_W + int'(in_data.pixel_col)] =
                            {in_data.red_in, in_data.green_in, in_data.blue_in};
                end
                else
                begin
                    find_taps(in_data.pixel_row, in_data.pixel_col, taps);
                    want = '0;
                    want.outside_frame = 1'b1;
                    if (taps.size() != 0)
                    begin
                        sum_r = 0;
                        sum_g = 0;
                        sum_b = 0;
                        foreach (taps[k])
                        begin
                            sum_r += frame_mem[taps[k]][23:16];
                            sum_g += frame_mem[taps[k]][15:8];
                            sum_b += frame_mem[taps[k]][7:0];
                        end
                        want.red_out   = 8'(sum_r / taps.size());
                        want.green_out = 8'(sum_g / taps.size());
                        want.blue_out  = 8'(sum_b / taps.size());
                        want.outside_frame = 1'b0;
                    end
                    expected_pixels.push_back(want);
                end
                items_taken++;
                if (items_taken % 48 == 0)
                    in_gap_max = draw_gap_limit();
                in_wait = $urandom_range(0, in_gap_max);
            end

            if (in_valid && !in_ready)
                ;
            else if (in_wait > 0)
            begin
                in_valid <= 1'b0;
                in_wait--;
            end
            else if (pending_items.size() > 0)
            begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output side: random back-pressure and an in-order check of every result transfer.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        out_item_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected pixel: expected none, got r=%02h g=%02h b=%02h out=%0b",
                             $time, out_data.red_out, out_data.green_out,
                             out_data.blue_out, out_data.outside_frame);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_data.red_out !== want.red_out || out_data.green_out !== want.green_out
                        || out_data.blue_out !== want.blue_out
                        || out_data.outside_frame !== want.outside_frame)
                    begin
                        fail_count++;
                        $display("%0t: pixel mismatch: expected r=%02h g=%02h b=%02h out=%0b, got r=%02h g=%02h b=%02h out=%0b",
                                 $time, want.red_out, want.green_out, want.blue_out,
                                 want.outside_frame, out_data.red_out, out_data.green_out,
                                 out_data.blue_out, out_data.outside_frame);
                    end
                end
                results_seen++;
                if (results_seen % 32 == 0)
                    out_gap_max = draw_gap_limit();
                out_wait = $urandom_range(0, out_gap_max);
            end

            if (out_wait > 0)
            begin
                out_ready <= 1'b0;
                out_wait--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL rotate_zoom_pixel_resampler_unit");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_mapping(input logic [COEF_W-1:0] cos_q, sin_q,
                               input logic [MODE_W-1:0] mode);
        write_reg(CFG_COS, cos_q);
        write_reg(CFG_SIN, sin_q);
        write_reg(CFG_MODE, COEF_W'(mode));
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, $urandom());
        // Let the register shadow settle before planning renders against it.
        @(negedge clk);
    endtask

    task automatic queue_write(input int row, col, input logic [CHAN_W-1:0] r, g, b);
        in_item_t item;
        int       slot;
        item.opcode    = OP_WRITE;
        item.pixel_row = COORD_W'(row);
        item.pixel_col = COORD_W'(col);
        item.red_in    = r;
        item.green_in  = g;
        item.blue_in   = b;
        pending_items.push_back(item);
        items_queued++;
        slot = row * FRAME_W + col;
        if (!planned[slot])
        begin
            planned[slot] = 1'b1;
            written_cells.push_back(slot);
        end
    endtask

    // A render is preceded by writes to any cell it reads that holds nothing yet.
    task automatic queue_render(input int row, col);
        in_item_t item;
        int       taps[$];
        item.opcode    = OP_RENDER;
        item.pixel_row = COORD_W'(row);
        item.pixel_col = COORD_W'(col);
        item.red_in    = 8'($urandom());
        item.green_in  = 8'($urandom());
        item.blue_in   = 8'($urandom());
        find_taps(item.pixel_row, item.pixel_col, taps);
        foreach (taps[k])
        begin
            if (!planned[taps[k]])
                queue_write(taps[k] / FRAME_W, taps[k] % FRAME_W, 8'($urandom()),
                            8'($urandom()), 8'($urandom()));
        end
        pending_items.push_back(item);
        items_queued++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (items_taken != items_queued || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_phase(input int budget);
        int first;
        int slot;
        first = items_queued;
        while (items_queued - first < budget)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    if (written_cells.size() > 0)
                    begin
                        slot = written_cells[$urandom_range(0, written_cells.size() - 1)];
                        queue_write(slot / FRAME_W, slot % FRAME_W, 8'($urandom()),
                                    8'($urandom()), 8'($urandom()));
                    end
                end
                2: queue_write($urandom_range(0, FRAME_H - 1), $urandom_range(0, FRAME_W - 1),
                               8'($urandom()), 8'($urandom()), 8'($urandom()));
                3, 4, 5: queue_render($urandom_range(0, FRAME_H - 1),
                                      $urandom_range(0, FRAME_W - 1));
                6, 7: queue_render($urandom_range(FRAME_H / 2 - 24, FRAME_H / 2 + 24),
                                   $urandom_range(FRAME_W / 2 - 24, FRAME_W / 2 + 24));
                default: queue_render($urandom_range(FRAME_H / 2 - 2, FRAME_H / 2 + 2),
                                      $urandom_range(FRAME_W / 2 - 2, FRAME_W / 2 + 2));
            endcase
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        logic [MODE_W-1:0] mode;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: identity mapping, nearest pixel, corners and the center.
        queue_write(0, 0, 8'hff, 8'hff, 8'hff);
        queue_write(FRAME_H - 1, FRAME_W - 1, 8'h00, 8'h00, 8'h00);
        queue_render(0, 0);
        queue_render(FRAME_H - 1, FRAME_W - 1);
        queue_render(FRAME_H / 2, FRAME_W / 2);
        wait_drained();

        // Box average of a saturated block, then samples on the outer ring.
        set_mapping(COS_RESET, SIN_RESET, MODE_BOX);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
                queue_write(r, c, 8'hff, 8'hff, 8'hff);
        end
        queue_render(1, 1);
        queue_render(0, 1);
        queue_render(FRAME_H - 1, FRAME_W - 1);
        wait_drained();

        // Exactly -0.5 falls off the frame; the last row, just under FRAME-0.5, stays on.
        set_mapping(32'd65664, SIN_RESET, MODE_NEAREST);
        queue_render(0, FRAME_W / 2);
        queue_render(FRAME_H - 1, FRAME_W / 2);
        queue_render(FRAME_H / 2, 0);
        wait_drained();

        // Half zoom: row 1 maps to 128.5 and rounds up.
        set_mapping(32'd32768, SIN_RESET, MODE_NEAREST);
        queue_render(1, FRAME_W / 2);
        wait_drained();

        set_mapping(draw_coef(), draw_coef(), MODE_BLANK);
        write_reg(CFG_UNUSED, '1);
        queue_render(FRAME_H / 2, FRAME_W / 2);
        queue_render(0, 0);
        wait_drained();

        // Coefficient extremes: only the center stays on the frame.
        set_mapping(32'h7fff_ffff, 32'h8000_0000, MODE_BOX);
        queue_render(FRAME_H / 2, FRAME_W / 2);
        random_phase(60);
        set_mapping(32'h8000_0000, 32'h7fff_ffff, MODE_ALT_NEAREST);
        queue_render(FRAME_H / 2, FRAME_W / 2);
        random_phase(60);

        for (int p = 0; p < 12; p++)
        begin
            case ($urandom_range(0, 7))
                0: mode = MODE_BLANK;
                1: mode = MODE_ALT_NEAREST;
                2, 3, 4: mode = MODE_NEAREST;
                default: mode = MODE_BOX;
            endcase
            set_mapping(draw_coef(), draw_coef(), mode);
            random_phase(130);
        end

        if (fail_count == 0)
            $display("PASS rotate_zoom_pixel_resampler_unit");
        else
            $display("FAIL rotate_zoom_pixel_resampler_unit");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rzpr_pkg.sv
src/rzpr_ram.sv
src/rotate_zoom_pixel_resampler_unit.sv
tb/sv/rotate_zoom_pixel_resampler_unit_tb.sv
